// ----- rtl/gbci_pkg.sv -----
// Shared widths and payload types for the gyro bias calibrate / integrate block.
// No dependencies; used by the channel interfaces and by all RTL modules.
`default_nettype none

package gbci_pkg;

  localparam int NAXES    = 3;
  localparam int RATE_W   = 16;
  localparam int STAMP_W  = 32;
  localparam int FRAC_W   = 8;
  localparam int SUM_W    = 24;
  localparam int BIAS_W   = 25;
  localparam int SCALED_W = RATE_W + FRAC_W;
  localparam int DIFF_W   = 26;
  localparam int PROD_W   = DIFF_W + STAMP_W + 1;
  localparam int ANGLE_W  = 64;

  typedef logic signed [RATE_W-1:0]   rate_t;
  typedef logic        [STAMP_W-1:0]  stamp_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [BIAS_W-1:0]   bias_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ANGLE_W-1:0]  angle_t;

endpackage

`default_nettype wire

// ----- rtl/gbci_if.sv -----
// Valid/ready channel interfaces: gyro sample requests in, angle results out.
// Depends on gbci_pkg for payload types.
`default_nettype none

interface gbci_in_if;
  logic             valid;
  logic             ready;
  gbci_pkg::rate_t  rate_x;
  gbci_pkg::rate_t  rate_y;
  gbci_pkg::rate_t  rate_z;
  gbci_pkg::stamp_t stamp_ms;

  modport source (output valid, output rate_x, output rate_y, output rate_z,
                  output stamp_ms, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                  input stamp_ms, output ready);
endinterface

interface gbci_out_if;
  logic             valid;
  logic             ready;
  logic             calibrating;
  gbci_pkg::angle_t angle_x;
  gbci_pkg::angle_t angle_y;
  gbci_pkg::angle_t angle_z;
  logic             clipped;

  modport source (output valid, output calibrating, output angle_x, output angle_y,
                  output angle_z, output clipped, input ready);
  modport sink   (input valid, input calibrating, input angle_x, input angle_y,
                  input angle_z, input clipped, output ready);
endinterface

`default_nettype wire

// ----- rtl/gbci_bias_div.sv -----
// Per-axis bias divider: bias = sum * 256 / DIVISOR, truncated toward zero.
// Reciprocal multiply then one-step remainder correction; depends on gbci_pkg.
`default_nettype none

module gbci_bias_div #(
  parameter int DIVISOR = 200
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire gbci_pkg::sum_t  sum,
  output gbci_pkg::bias_t      bias
);

  localparam int DIVW = gbci_pkg::SUM_W + gbci_pkg::FRAC_W;
  // floor(2^DIVW / DIVISOR); estimate is exact or one low for any dividend < 2^(DIVW-1)
  localparam logic [DIVW:0] RECIP = (DIVW+1)'((64'd1 << DIVW) / 64'(DIVISOR));
  localparam logic [DIVW:0] DIV_V = (DIVW+1)'(DIVISOR);

  logic [gbci_pkg::SUM_W-1:0]  mag_c;
  logic [DIVW-1:0]             dvd_c;
  logic [2*DIVW:0]             prod_c;

  logic                        neg_r;
  logic [DIVW-1:0]             dvd_r;
  logic [gbci_pkg::BIAS_W-1:0] est_r;
  logic                        fix_r;
  gbci_pkg::bias_t             bias_r, bias_nxt;

  logic [DIVW:0]               back_c;
  logic [DIVW:0]               rem_c;
  logic [gbci_pkg::BIAS_W-1:0] quo_c;

  always_comb begin
    mag_c  = sum[gbci_pkg::SUM_W-1] ? gbci_pkg::SUM_W'(-sum) : gbci_pkg::SUM_W'(sum);
    dvd_c  = {mag_c, gbci_pkg::FRAC_W'(0)};
    prod_c = (2*DIVW+1)'(dvd_c) * (2*DIVW+1)'(RECIP);
  end

  always_comb begin
    back_c   = (DIVW+1)'(est_r) * DIV_V;
    rem_c    = (DIVW+1)'(dvd_r) - back_c;
    quo_c    = (rem_c >= DIV_V) ? est_r + gbci_pkg::BIAS_W'(1) : est_r;
    bias_nxt = bias_r;
    if (fix_r) begin
      bias_nxt = neg_r ? -$signed(quo_c) : $signed(quo_c);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= sum[gbci_pkg::SUM_W-1];
      dvd_r <= dvd_c;
      est_r <= prod_c[DIVW +: gbci_pkg::BIAS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fix_r  <= 1'b0;
      bias_r <= '0;
    end else begin
      fix_r  <= start;
      bias_r <= bias_nxt;
    end
  end

  assign bias = bias_r;

endmodule

`default_nettype wire

// ----- rtl/gyro_bias_calibrate_integrate_unit.sv -----
// Gyro bias calibration and rate integration, three axes.
// Stages from request accept to result valid: input reg loads on accept,
//   then product reg, then accumulator.
// Throughput: one request per cycle while out_chan.ready allows; input is also held off
//   after the last calibration request, while the bias divider (reciprocal multiply + correction) settles.
// Reset (sync, active low) clears calibration count, sums, biases, angles and time reference.
// Depends on gbci_pkg, gbci_if and gbci_bias_div.
`default_nettype none

module gyro_bias_calibrate_integrate_unit #(
  parameter int CAL_SAMPLES = 200
) (
  input  wire        clk,
  input  wire        rst_n,
  gbci_in_if.sink    in_chan,
  gbci_out_if.source out_chan
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int NAX   = gbci_pkg::NAXES;
  localparam int AW    = gbci_pkg::ANGLE_W;

  // calibration / time reference state
  logic [CNT_W-1:0]  calib_count_r, calib_count_nxt;
  gbci_pkg::sum_t    sum_r [NAX];
  gbci_pkg::sum_t    sum_nxt [NAX];
  gbci_pkg::stamp_t  prev_stamp_r, prev_stamp_nxt;
  logic              stamp_seen_r, stamp_seen_nxt;
  logic              bias_go_r, bias_go_nxt;
  gbci_pkg::bias_t   bias_w [NAX];

  // pipeline
  logic              s1_v_r, s1_cal_r;
  gbci_pkg::rate_t   s1_rate_r [NAX];
  gbci_pkg::stamp_t  s1_dt_r;
  logic              s2_v_r, s2_cal_r;
  gbci_pkg::prod_t   s2_prod_r [NAX];
  logic              out_v_r, out_cal_r, out_clip_r, out_clip_nxt;
  gbci_pkg::angle_t  angle_r [NAX];
  gbci_pkg::angle_t  angle_nxt [NAX];

  logic              en1, en2, en3, in_rdy, accept;
  logic              is_cal, is_last;
  gbci_pkg::rate_t   in_rate [NAX];
  gbci_pkg::scaled_t scaled_c [NAX];
  gbci_pkg::diff_t   diff_c [NAX];
  gbci_pkg::prod_t   prod_c [NAX];
  logic signed [gbci_pkg::STAMP_W:0] dt_s;
  logic signed [AW:0] acc_c [NAX];

  assign in_rate[0] = in_chan.rate_x;
  assign in_rate[1] = in_chan.rate_y;
  assign in_rate[2] = in_chan.rate_z;

  // each stage moves when the one after it is empty or moving
  assign en3    = !out_v_r || out_chan.ready;
  assign en2    = !s2_v_r || en3;
  assign en1    = !s1_v_r || en2;
  assign in_rdy = en1 && !bias_go_r;
  assign accept = in_chan.valid && in_rdy;

  assign is_cal  = calib_count_r < CNT_W'(CAL_SAMPLES);
  assign is_last = calib_count_r == CNT_W'(CAL_SAMPLES - 1);

  always_comb begin
    calib_count_nxt = calib_count_r;
    prev_stamp_nxt  = prev_stamp_r;
    stamp_seen_nxt  = stamp_seen_r;
    bias_go_nxt     = 1'b0;
    for (int i = 0; i < NAX; i++) begin
      sum_nxt[i] = sum_r[i];
    end
    if (accept) begin
      if (!stamp_seen_r) begin
        prev_stamp_nxt = in_chan.stamp_ms;
        stamp_seen_nxt = 1'b1;
      end
      if (is_cal) begin
        for (int i = 0; i < NAX; i++) begin
          sum_nxt[i] = sum_r[i] + gbci_pkg::SUM_W'(in_rate[i]);
        end
        calib_count_nxt = calib_count_r + CNT_W'(1);
        bias_go_nxt     = is_last;
      end else begin
        prev_stamp_nxt = in_chan.stamp_ms;
      end
    end
  end

  gbci_bias_div #(.DIVISOR(CAL_SAMPLES)) u_div_0 (
    .clk(clk), .rst_n(rst_n), .start(bias_go_r), .sum(sum_r[0]), .bias(bias_w[0])
  );
  gbci_bias_div #(.DIVISOR(CAL_SAMPLES)) u_div_1 (
    .clk(clk), .rst_n(rst_n), .start(bias_go_r), .sum(sum_r[1]), .bias(bias_w[1])
  );
  gbci_bias_div #(.DIVISOR(CAL_SAMPLES)) u_div_2 (
    .clk(clk), .rst_n(rst_n), .start(bias_go_r), .sum(sum_r[2]), .bias(bias_w[2])
  );

  // (rate*256 - bias) * dt, one multiplier per axis
  always_comb begin
    dt_s = $signed({1'b0, s1_dt_r});
    for (int i = 0; i < NAX; i++) begin
      scaled_c[i] = {s1_rate_r[i], gbci_pkg::FRAC_W'(0)};
      diff_c[i]   = gbci_pkg::DIFF_W'(scaled_c[i]) - gbci_pkg::DIFF_W'(bias_w[i]);
      prod_c[i]   = diff_c[i] * dt_s;
    end
  end

  // saturating accumulate; overflow when the two top bits of the wide sum differ
  always_comb begin
    out_clip_nxt = 1'b0;
    for (int i = 0; i < NAX; i++) begin
      acc_c[i]     = (AW+1)'(angle_r[i]) + (AW+1)'(s2_prod_r[i]);
      angle_nxt[i] = angle_r[i];
      if (s2_v_r && !s2_cal_r) begin
        if (acc_c[i][AW] != acc_c[i][AW-1]) begin
          angle_nxt[i] = acc_c[i][AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
          out_clip_nxt = 1'b1;
        end else begin
          angle_nxt[i] = acc_c[i][AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_count_r <= '0;
      prev_stamp_r  <= '0;
      stamp_seen_r  <= 1'b0;
      bias_go_r     <= 1'b0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      for (int i = 0; i < NAX; i++) begin
        sum_r[i]   <= '0;
        angle_r[i] <= '0;
      end
    end else begin
      calib_count_r <= calib_count_nxt;
      prev_stamp_r  <= prev_stamp_nxt;
      stamp_seen_r  <= stamp_seen_nxt;
      bias_go_r     <= bias_go_nxt;
      for (int i = 0; i < NAX; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
      if (en1) begin
        s1_v_r <= accept;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        out_v_r <= s2_v_r;
        for (int i = 0; i < NAX; i++) begin
          angle_r[i] <= angle_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cal_r <= is_cal;
      s1_dt_r  <= in_chan.stamp_ms - prev_stamp_r;
      for (int i = 0; i < NAX; i++) begin
        s1_rate_r[i] <= in_rate[i];
      end
    end
    if (en2 && s1_v_r) begin
      s2_cal_r <= s1_cal_r;
      for (int i = 0; i < NAX; i++) begin
        s2_prod_r[i] <= prod_c[i];
      end
    end
    if (en3 && s2_v_r) begin
      out_cal_r  <= s2_cal_r;
      out_clip_r <= out_clip_nxt;
    end
  end

  assign in_chan.ready        = in_rdy;
  assign out_chan.valid       = out_v_r;
  assign out_chan.calibrating = out_cal_r;
  assign out_chan.angle_x     = angle_r[0];
  assign out_chan.angle_y     = angle_r[1];
  assign out_chan.angle_z     = angle_r[2];
  assign out_chan.clipped     = out_clip_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    calib_count_r <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count past limit");

  a_bias_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_cal_r) |-> (!bias_go_r && !$past(bias_go_r)))
    else $error("integration request reached multiplier before bias settled");

  a_cal_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_cal_r) |-> !out_clip_r)
    else $error("calibration result flagged as clipped");

  a_cal_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (en3 && s2_v_r && s2_cal_r) |=> (angle_r[0] == $past(angle_r[0])))
    else $error("angle moved on a calibration request");

endmodule

`default_nettype wire
